@@ rtl/core/nearest_neighbour_glyph_scaler_macros.svh @@
// Assertion macros used by the checker file of the glyph scaler.
`ifndef NEAREST_NEIGHBOUR_GLYPH_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOUR_GLYPH_SCALER_MACROS_SVH

// The consequent is checked at the same clock edge as the antecedent.
`define NNGS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent is checked at the clock edge after the antecedent.
`define NNGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/nngs_pkg.sv @@
package nngs_pkg;

	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_FRAME_COUNT = 4;

	localparam int GLYPH_W = 21;
	localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 21'h00020;

	localparam int CFG_DATA_W = 10;

	localparam logic [7:0] RST_SRC_WIDTH  = 8'd128;
	localparam logic [6:0] RST_SRC_HEIGHT = 7'd64;
	localparam logic [9:0] RST_DST_WIDTH  = 10'd128;
	localparam logic [8:0] RST_DST_HEIGHT = 9'd64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_NUM_W = 18;
	localparam int DIV_DEN_W = 10;
	localparam int DIV_ITER  = DIV_NUM_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		op_t          op;
		logic [1:0]   frame_sel;
		logic [8:0]   column;
		logic [7:0]   row;
		logic [20:0]  glyph_in;
	} in_beat_t;

	typedef struct packed {
		logic [20:0]  glyph_out;
		logic         out_of_range;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]   src_width;
		logic [6:0]   src_height;
		logic [9:0]   dst_width;
		logic [8:0]   dst_height;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FLAG  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic [1:0]   frame_sel;
		logic [8:0]   column;
		logic [7:0]   row;
		logic [20:0]  glyph;
		logic [16:0]  num_x;
		logic [14:0]  num_y;
	} cmd_t;

	typedef struct packed {
		logic         start;
		logic [16:0]  num_x;
		logic [9:0]   den_x;
		logic [14:0]  num_y;
		logic [8:0]   den_y;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo_x;
		logic [DIV_NUM_W-1:0] quo_y;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR  = 2'd0,
		ST_IDLE   = 2'd1,
		ST_DIVIDE = 2'd2,
		ST_FETCH  = 2'd3
	} back_state_t;

endpackage

@@ rtl/core/nearest_neighbour_glyph_scaler.sv @@
// Glyph store of FRAME_COUNT frames of MAX_ROWS x MAX_COLUMNS cells, scaled on read.
// Input channel (in_valid, in_stall, in_beat): a write beat stores glyph_in at a
// source cell and gives no result; a read beat maps its destination cell to a source
// cell by nearest neighbor and gives one output beat. Writes outside the source grid
// are dropped; reads outside the destination grid or frame range return
// out_of_range with a zero glyph.
// Output channel (out_valid, out_stall, out_beat): a beat is held while out_stall is
// high; a two-entry command queue keeps taking input beats meanwhile.
// Configuration port: cfg_we, cfg_index, cfg_data, written only while idle; the user
// keeps to this, as the block itself does not enforce it.
// Back end: a write, or a flagged read once the output register is free, is handled
// in ST_IDLE. An in-range read starts the divider, which produces both source
// coordinates in parallel, two quotient bits per cycle; the store is then read, and
// ST_FETCH loads the output beat. The next command waits in the queue until then.
// Reset: every cell of the store is filled with spaces, one cell per cycle; in_stall
// is high while the store is cleared, and configuration writes are still taken.
module nearest_neighbour_glyph_scaler #(
	parameter int MAX_COLUMNS = nngs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = nngs_pkg::DEF_MAX_ROWS,
	parameter int FRAME_COUNT = nngs_pkg::DEF_FRAME_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  nngs_pkg::in_beat_t              in_beat,
	output logic                            out_valid,
	input  logic                            out_stall,
	output nngs_pkg::out_beat_t             out_beat,
	input  logic                            cfg_we,
	input  nngs_pkg::cfg_reg_t              cfg_index,
	input  logic [nngs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nngs_pkg::*;

	cfg_t     cfg;
	logic     push;
	cmd_t     push_cmd;
	logic     q_full;
	logic     head_valid;
	cmd_t     head;
	logic     pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     clearing;

	nngs_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.FRAME_COUNT(FRAME_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.clearing (clearing),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.cfg      (cfg)
	);

	nngs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	nngs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	nngs_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.FRAME_COUNT(FRAME_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.clearing  (clearing)
	);

endmodule

@@ rtl/core/nngs_fifo.sv @@
module nngs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nngs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output nngs_pkg::cmd_t head
);
	import nngs_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/nngs_div.sv @@
module nngs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  nngs_pkg::div_req_t req,
	output nngs_pkg::div_rsp_t rsp
);
	import nngs_pkg::*;

	// Two restoring steps per cycle for each of the two quotients.
	function automatic logic [DIV_DEN_W:0] div_step(
		logic [DIV_DEN_W-1:0] rem,
		logic                 nb,
		logic [DIV_DEN_W-1:0] den
	);
		logic [DIV_DEN_W:0] p;
		logic [DIV_DEN_W:0] d;
		p = {rem, nb};
		d = {1'b0, den};
		if (p >= d) begin
			return {1'b1, DIV_DEN_W'(p - d)};
		end
		return {1'b0, p[DIV_DEN_W-1:0]};
	endfunction

	logic [DIV_NUM_W-1:0] nx_q, ny_q;
	logic [DIV_NUM_W-1:0] qx_q, qy_q;
	logic [DIV_DEN_W-1:0] rx_q, ry_q;
	logic [DIV_DEN_W-1:0] dx_q, dy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   sx1, sx2, sy1, sy2;

	assign sx1 = div_step(rx_q, nx_q[DIV_NUM_W-1], dx_q);
	assign sx2 = div_step(sx1[DIV_DEN_W-1:0], nx_q[DIV_NUM_W-2], dx_q);
	assign sy1 = div_step(ry_q, ny_q[DIV_NUM_W-1], dy_q);
	assign sy2 = div_step(sy1[DIV_DEN_W-1:0], ny_q[DIV_NUM_W-2], dy_q);

	always_ff @(posedge clk) begin
		if (req.start) begin
			nx_q <= DIV_NUM_W'(req.num_x);
			ny_q <= DIV_NUM_W'(req.num_y);
			rx_q <= '0;
			ry_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			dx_q <= DIV_DEN_W'(req.den_x);
			dy_q <= DIV_DEN_W'(req.den_y);
		end else if (busy_q) begin
			nx_q <= {nx_q[DIV_NUM_W-3:0], 2'b00};
			ny_q <= {ny_q[DIV_NUM_W-3:0], 2'b00};
			rx_q <= sx2[DIV_DEN_W-1:0];
			ry_q <= sy2[DIV_DEN_W-1:0];
			qx_q <= {qx_q[DIV_NUM_W-3:0], sx1[DIV_DEN_W], sx2[DIV_DEN_W]};
			qy_q <= {qy_q[DIV_NUM_W-3:0], sy1[DIV_DEN_W], sy2[DIV_DEN_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.quo_x = qx_q;
	assign rsp.quo_y = qy_q;

endmodule

@@ rtl/core/nngs_front.sv @@
module nngs_front #(
	parameter int MAX_COLUMNS = nngs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = nngs_pkg::DEF_MAX_ROWS,
	parameter int FRAME_COUNT = nngs_pkg::DEF_FRAME_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  nngs_pkg::cfg_reg_t              cfg_index,
	input  logic [nngs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  nngs_pkg::in_beat_t              in_beat,
	input  logic                            clearing,
	input  logic                            q_full,
	output logic                            push,
	output nngs_pkg::cmd_t                  push_cmd,
	output nngs_pkg::cfg_t                  cfg
);
	import nngs_pkg::*;

	cfg_t cfg_q;
	logic wr_ok;
	logic rd_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= RST_SRC_WIDTH;
			cfg_q.src_height <= RST_SRC_HEIGHT;
			cfg_q.dst_width  <= RST_DST_WIDTH;
			cfg_q.dst_height <= RST_DST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  cfg_q.src_width  <= 8'(cfg_data);
				REG_SRC_HEIGHT: cfg_q.src_height <= 7'(cfg_data);
				REG_DST_WIDTH:  cfg_q.dst_width  <= 10'(cfg_data);
				REG_DST_HEIGHT: cfg_q.dst_height <= 9'(cfg_data);
			endcase
		end
	end

	assign cfg = cfg_q;

	always_comb begin
		wr_ok = (32'(in_beat.frame_sel) < FRAME_COUNT) &&
			(in_beat.column < {1'b0, cfg_q.src_width}) &&
			(32'(in_beat.column) < MAX_COLUMNS) &&
			(in_beat.row < {1'b0, cfg_q.src_height}) &&
			(32'(in_beat.row) < MAX_ROWS);
		rd_flag = (32'(in_beat.frame_sel) >= FRAME_COUNT) ||
			({1'b0, in_beat.column} >= cfg_q.dst_width) ||
			({1'b0, in_beat.row} >= cfg_q.dst_height);
	end

	assign in_stall = clearing || q_full;

	always_comb begin
		push_cmd.frame_sel = in_beat.frame_sel;
		push_cmd.column    = in_beat.column;
		push_cmd.row       = in_beat.row;
		push_cmd.glyph     = in_beat.glyph_in;
		push_cmd.num_x     = 17'(in_beat.column) * 17'(cfg_q.src_width);
		push_cmd.num_y     = 15'(in_beat.row) * 15'(cfg_q.src_height);
		push_cmd.kind      = CMD_WRITE;
		push               = 1'b0;
		if (in_valid && !in_stall) begin
			unique case (in_beat.op)
				OP_WRITE: begin
					push = wr_ok;
				end
				OP_READ: begin
					push          = 1'b1;
					push_cmd.kind = rd_flag ? CMD_FLAG : CMD_READ;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/nngs_back.sv @@
module nngs_back #(
	parameter int MAX_COLUMNS = nngs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = nngs_pkg::DEF_MAX_ROWS,
	parameter int FRAME_COUNT = nngs_pkg::DEF_FRAME_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  nngs_pkg::cmd_t      head,
	output logic                pop,
	input  nngs_pkg::cfg_t      cfg,
	output nngs_pkg::div_req_t  div_req,
	input  nngs_pkg::div_rsp_t  div_rsp,
	output logic                out_valid,
	input  logic                out_stall,
	output nngs_pkg::out_beat_t out_beat,
	output logic                clearing
);
	import nngs_pkg::*;

	localparam int XW              = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int YW              = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int FW              = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int CELLS_PER_FRAME = MAX_ROWS * MAX_COLUMNS;
	localparam int CELLS           = FRAME_COUNT * CELLS_PER_FRAME;
	localparam int AW              = (CELLS > 1) ? $clog2(CELLS) : 1;

	function automatic logic [AW-1:0] cell_addr(
		logic [FW-1:0] f,
		logic [YW-1:0] y,
		logic [XW-1:0] x
	);
		return AW'(int'(f) * CELLS_PER_FRAME + int'(y) * MAX_COLUMNS + int'(x));
	endfunction

	logic [GLYPH_W-1:0] mem [CELLS];
	logic [GLYPH_W-1:0] rd_q;

	back_state_t        state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [1:0]         frame_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [GLYPH_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [XW-1:0]      sx;
	logic [YW-1:0]      sy;
	logic               out_free;
	logic               out_load;
	out_beat_t          out_next;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Source coordinates past the stored grid clamp to its last column and row.
	always_comb begin
		sx = (div_rsp.quo_x >= DIV_NUM_W'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS - 1) :
			XW'(div_rsp.quo_x);
		sy = (div_rsp.quo_y >= DIV_NUM_W'(MAX_ROWS)) ? YW'(MAX_ROWS - 1) :
			YW'(div_rsp.quo_y);
		mem_raddr = cell_addr(FW'(frame_q), sy, sx);
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d           = state_q;
		pop               = 1'b0;
		mem_we            = 1'b0;
		mem_waddr         = cell_addr(FW'(head.frame_sel), YW'(head.row), XW'(head.column));
		mem_wdata         = head.glyph;
		mem_re            = 1'b0;
		div_req.start     = 1'b0;
		div_req.num_x     = head.num_x;
		div_req.den_x     = cfg.dst_width;
		div_req.num_y     = head.num_y;
		div_req.den_y     = cfg.dst_height;
		out_load          = 1'b0;
		out_next          = '{glyph_out: rd_q, out_of_range: 1'b0};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = SPACE_GLYPH;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.kind)
						CMD_WRITE: begin
							mem_we = 1'b1;
							pop    = 1'b1;
						end
						CMD_FLAG: begin
							if (out_free) begin
								out_load = 1'b1;
								out_next = '{glyph_out: '0, out_of_range: 1'b1};
								pop      = 1'b1;
							end
						end
						CMD_READ: begin
							div_req.start = 1'b1;
							pop           = 1'b1;
							state_d       = ST_DIVIDE;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					mem_re  = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head_valid && head.kind == CMD_READ) begin
			frame_q <= head.frame_sel;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;
	assign clearing  = (state_q == ST_CLEAR);

endmodule

@@ rtl/core/nngs_checker.sv @@
`include "nearest_neighbour_glyph_scaler_macros.svh"

module nngs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input nngs_pkg::in_beat_t              in_beat,
	input logic                            out_valid,
	input logic                            out_stall,
	input nngs_pkg::out_beat_t             out_beat,
	input logic                            cfg_we
);
	import nngs_pkg::*;

	`NNGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_beat), "stalled output beat changed")

	`NNGS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_beat), "stalled input beat changed")

	`NNGS_ASSERT_SAME(a_flag_zero, clk, arst_n, out_valid && out_beat.out_of_range, out_beat.glyph_out == '0, "flagged beat carries a glyph")

	`NNGS_ASSERT_SAME(a_reset_clear, clk, arst_n, $past(arst_n) == 1'b0, in_stall && !out_valid, "input taken or output shown while the store is cleared")

	`NNGS_ASSERT_SAME(a_cfg_idle, clk, arst_n, cfg_we, !in_valid && !out_valid, "configuration written while beats are in flight")

endmodule

bind nearest_neighbour_glyph_scaler nngs_checker u_nngs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_beat  (in_beat),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_beat (out_beat),
	.cfg_we   (cfg_we)
);

@@ test/nearest_neighbour_glyph_scaler_checker.sv @@
`timescale 1ns / 100ps

module nearest_neighbour_glyph_scaler_checker
	import nngs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_beat_t  in_beat,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_beat_t out_beat,
	input  logic      cfg_we,
	input  cfg_reg_t  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int        fail_count,
	output int        waiting
);

	localparam int CELLS = DEF_FRAME_COUNT * DEF_MAX_ROWS * DEF_MAX_COLUMNS;

	logic [GLYPH_W-1:0] source_cells [CELLS];
	cfg_t               sizes;
	out_beat_t          expected_glyphs [$];
	int                 mismatches;

	function automatic int unsigned cell_addr(int unsigned f, int unsigned y, int unsigned x);
		return (f * DEF_MAX_ROWS + y) * DEF_MAX_COLUMNS + x;
	endfunction

	function automatic out_beat_t scaled_glyph(in_beat_t b);
		int unsigned sx;
		int unsigned sy;
		out_beat_t   r;
		r = '0;
		if (32'(b.frame_sel) >= DEF_FRAME_COUNT || b.column >= sizes.dst_width ||
				b.row >= sizes.dst_height) begin
			r.out_of_range = 1'b1;
			return r;
		end
		sx = (32'(b.column) * 32'(sizes.src_width)) / 32'(sizes.dst_width);
		sy = (32'(b.row) * 32'(sizes.src_height)) / 32'(sizes.dst_height);
		if (sx >= DEF_MAX_COLUMNS) sx = DEF_MAX_COLUMNS - 1;
		if (sy >= DEF_MAX_ROWS) sy = DEF_MAX_ROWS - 1;
		r.glyph_out = source_cells[cell_addr(b.frame_sel, sy, sx)];
		return r;
	endfunction

	function automatic void store_glyph(in_beat_t b);
		if (32'(b.frame_sel) < DEF_FRAME_COUNT &&
				b.column < sizes.src_width && 32'(b.column) < DEF_MAX_COLUMNS &&
				b.row < sizes.src_height && 32'(b.row) < DEF_MAX_ROWS)
			source_cells[cell_addr(b.frame_sel, b.row, b.column)] = b.glyph_in;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) source_cells[i] = SPACE_GLYPH;
			sizes = '{RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_DST_WIDTH, RST_DST_HEIGHT};
			expected_glyphs.delete();
			mismatches = 0;
			fail_count <= 0;
			waiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_glyphs.size() == 0) begin
					$error("output beat with no read waiting: glyph_out %h, out_of_range %b",
						out_beat.glyph_out, out_beat.out_of_range);
					mismatches++;
				end else begin
					want = expected_glyphs.pop_front();
					if (out_beat.glyph_out !== want.glyph_out) begin
						$error("glyph_out: expected %h, actual %h",
							want.glyph_out, out_beat.glyph_out);
						mismatches++;
					end
					if (out_beat.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %b, actual %b",
							want.out_of_range, out_beat.out_of_range);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_beat.op == OP_READ)
					expected_glyphs.push_back(scaled_glyph(in_beat));
				else
					store_glyph(in_beat);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH: sizes.src_width = cfg_data[7:0];
					REG_SRC_HEIGHT: sizes.src_height = cfg_data[6:0];
					REG_DST_WIDTH: sizes.dst_width = cfg_data[9:0];
					REG_DST_HEIGHT: sizes.dst_height = cfg_data[8:0];
					default: ;
				endcase
			end
			fail_count <= mismatches;
			waiting <= expected_glyphs.size();
		end
	end

endmodule

@@ test/nearest_neighbour_glyph_scaler_tb.sv @@
`timescale 1ns / 100ps

module nearest_neighbour_glyph_scaler_tb;
	import nngs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_beat_t              in_beat;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_beat_t             out_beat;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int waiting;
	int idle_pct   = 0;
	int stall_left = 0;

	logic [7:0] cur_sw = RST_SRC_WIDTH;
	logic [6:0] cur_sh = RST_SRC_HEIGHT;
	logic [9:0] cur_dw = RST_DST_WIDTH;
	logic [8:0] cur_dh = RST_DST_HEIGHT;

	nearest_neighbour_glyph_scaler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	nearest_neighbour_glyph_scaler_checker glyph_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic in_beat_t beat_of(op_t op, int f, int c, int r, int g);
		in_beat_t b;
		b.op = op;
		b.frame_sel = 2'(f);
		b.column = 9'(c);
		b.row = 8'(r);
		b.glyph_in = 21'(g);
		return b;
	endfunction

	function automatic in_beat_t random_item();
		in_beat_t    b;
		int unsigned pick;
		int unsigned wlim;
		int unsigned hlim;
		b.op = OP_WRITE;
		b.frame_sel = 2'($urandom_range(0, 3));
		b.column = 9'($urandom_range(0, 511));
		b.row = 8'($urandom_range(0, 255));
		b.glyph_in = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(32, 126))
			: 21'($urandom_range(0, 21'h1FFFFF));
		wlim = (32'(cur_sw) < DEF_MAX_COLUMNS) ? 32'(cur_sw) : DEF_MAX_COLUMNS;
		hlim = (32'(cur_sh) < DEF_MAX_ROWS) ? 32'(cur_sh) : DEF_MAX_ROWS;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if (wlim > 0) b.column = 9'($urandom_range(0, wlim - 1));
			if (hlim > 0) b.row = 8'($urandom_range(0, hlim - 1));
		end else if (pick < 85) begin
			b.op = OP_READ;
			if (cur_dw > 0) b.column = 9'($urandom_range(0, 32'(cur_dw) - 1));
			if (cur_dh > 0) b.row = 8'($urandom_range(0, 32'(cur_dh) - 1));
		end else begin
			b.op = op_t'($urandom_range(0, 1));
		end
		return b;
	endfunction

	task automatic send_beat(input in_beat_t b);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_sizes(input logic [9:0] sw, input logic [9:0] sh,
			input logic [9:0] dw, input logic [9:0] dh);
		cfg_we <= 1'b1;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= sw;
		@(posedge clk);
		cfg_index <= REG_SRC_HEIGHT;
		cfg_data <= sh;
		@(posedge clk);
		cfg_index <= REG_DST_WIDTH;
		cfg_data <= dw;
		@(posedge clk);
		cfg_index <= REG_DST_HEIGHT;
		cfg_data <= dh;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_sw = sw[7:0];
		cur_sh = sh[6:0];
		cur_dw = dw[9:0];
		cur_dh = dh[8:0];
	endtask

	task automatic run_phase(input int sw, input int sh, input int dw, input int dh,
			input int count, input int pct);
		program_sizes(10'(sw), 10'(sh), 10'(dw), 10'(dh));
		idle_pct = pct;
		repeat (count) send_beat(random_item());
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_beat <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;

		// Corner cells, codes above the valid range, writes outside the grid
		// and reads outside the destination grid, at the reset sizes.
		send_beat(beat_of(OP_WRITE, 0, 0, 0, 21'h1FFFFF));
		send_beat(beat_of(OP_WRITE, 3, 127, 63, 0));
		send_beat(beat_of(OP_WRITE, 1, 5, 7, 21'h41));
		send_beat(beat_of(OP_WRITE, 2, 128, 0, 21'h123));
		send_beat(beat_of(OP_WRITE, 2, 0, 64, 21'h456));
		send_beat(beat_of(OP_WRITE, 2, 511, 255, 21'h10FFFF));
		send_beat(beat_of(OP_WRITE, 2, 127, 1, 21'h110000));
		send_beat(beat_of(OP_READ, 0, 0, 0, 21'h1FFFFF));
		send_beat(beat_of(OP_READ, 3, 127, 63, 0));
		send_beat(beat_of(OP_READ, 1, 5, 7, 21'h0AAAAA));
		send_beat(beat_of(OP_READ, 2, 0, 0, 0));
		send_beat(beat_of(OP_READ, 2, 127, 1, 0));
		send_beat(beat_of(OP_READ, 2, 127, 0, 0));
		send_beat(beat_of(OP_READ, 0, 128, 0, 0));
		send_beat(beat_of(OP_READ, 0, 0, 64, 0));
		send_beat(beat_of(OP_READ, 3, 511, 255, 21'h1FFFFF));
		send_beat(beat_of(OP_WRITE, 1, 5, 7, 21'h42));
		send_beat(beat_of(OP_READ, 1, 5, 7, 0));
		settle();

		run_phase(128, 64, 512, 256, 220, 25);
		run_phase(1, 1, 1, 1, 150, 40);
		run_phase(255, 127, 64, 32, 200, 15);
		run_phase(0, 0, 100, 50, 150, 30);
		run_phase(128, 64, 0, 0, 60, 25);
		run_phase($urandom_range(1, 128), $urandom_range(1, 64),
			$urandom_range(1, 512), $urandom_range(1, 256), 220, 30);
		run_phase($urandom_range(1, 128), $urandom_range(1, 64),
			$urandom_range(1, 64), $urandom_range(1, 32), 220, 0);
		run_phase($urandom_range(1, 16), $urandom_range(1, 8),
			$urandom_range(1, 512), $urandom_range(1, 256), 220, 35);
		run_phase($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), 150, 20);
		run_phase(128, 64, 128, 64, 290, 0);

		if (fail_count == 0)
			$display("nearest_neighbour_glyph_scaler_tb: done, clean");
		else
			$display("nearest_neighbour_glyph_scaler_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("nearest_neighbour_glyph_scaler_tb: done, errors");
		$finish;
	end

endmodule
